// ===== rtl/core/collinear_point_merge_assert.svh =====
// ----------------------------------------------------------------------------
// collinear_point_merge assertion macros
// Shared property forms for the collinear point merge block. They expect
// clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef COLLINEAR_POINT_MERGE_ASSERT_SVH
`define COLLINEAR_POINT_MERGE_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define CPM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define CPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cpm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpm_pkg
// Types and constants shared by the collinear point merge block: the input
// and result words, command codes, controller/datapath signal groups and the
// product schedule of the collinearity test.
// ----------------------------------------------------------------------------
`default_nettype none

package cpm_pkg;

  // Input word.
  typedef struct packed {
    logic [2:0]         command;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
    logic [15:0]        speed_in;
    logic signed [15:0] sync_window;
    logic [7:0]         sync_tag;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic [23:0]        out_speed;
    logic signed [15:0] out_sync_window;
    logic [7:0]         out_sync_tag;
    logic               last_point;
  } out_word_t;

  localparam int unsigned COORD_IN_W = 24;
  localparam int unsigned MUL_W      = 32;

  // Command codes.
  localparam logic [2:0] CMD_REL      = 3'd0;
  localparam logic [2:0] CMD_ABS      = 3'd1;
  localparam logic [2:0] CMD_SET_REF  = 3'd2;
  localparam logic [2:0] CMD_REF_LAST = 3'd3;
  localparam logic [2:0] CMD_FLUSH    = 3'd4;

  // Configuration register indexes and reset values.
  localparam logic       REG_SPEED_SCALE = 1'b0;
  localparam logic       REG_TOL_SQ      = 1'b1;
  localparam logic [15:0] SPEED_SCALE_RST = 16'd256;
  localparam logic [62:0] TOL_SQ_RST      = 63'd1;

  // Point count codes.
  localparam logic [1:0] CNT_EMPTY   = 2'd0;
  localparam logic [1:0] CNT_PENDING = 2'd1;
  localparam logic [1:0] CNT_BOTH    = 2'd2;

  // 1.0 in Q4.12.
  localparam logic signed [15:0] SYNC_ONE = 16'sd4096;

  // Product schedule: three cross terms, their squares and the dot product.
  localparam int unsigned NUM_STEPS = 12;
  localparam int unsigned STEP_W    = $clog2(NUM_STEPS);
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_LAST = step_t'(NUM_STEPS - 1);

  typedef logic [1:0] lane_t;

  typedef enum logic [2:0] {
    K_LOAD,
    K_SUB,
    K_DOT_LOAD,
    K_DOT_ADD,
    K_SQ
  } kind_t;

  localparam kind_t STEP_KIND [NUM_STEPS] = '{
    K_LOAD, K_SUB, K_DOT_LOAD, K_SQ,
    K_LOAD, K_SUB, K_DOT_ADD,  K_SQ,
    K_LOAD, K_SUB, K_DOT_ADD,  K_SQ
  };
  localparam lane_t STEP_A [NUM_STEPS] = '{
    2'd1, 2'd2, 2'd0, 2'd0,
    2'd2, 2'd0, 2'd1, 2'd0,
    2'd0, 2'd1, 2'd2, 2'd0
  };
  localparam lane_t STEP_C [NUM_STEPS] = '{
    2'd2, 2'd1, 2'd0, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd0,
    2'd1, 2'd0, 2'd2, 2'd0
  };

  // Controller to datapath.
  typedef struct packed {
    logic  load_in;
    logic  prep;
    logic  diff;
    logic  mul_en;
    step_t step;
    logic  calc_ran;
    logic  commit;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_calc;
    logic emit_req;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/cpm_datapath.sv =====
// ----------------------------------------------------------------------------
// cpm_datapath
// Path state, reference update, difference vectors, the shared multiplier
// with its accumulators, the merge decision and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpm_datapath #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cpm_pkg::dp_cmd_t    cmd,
  output cpm_pkg::dp_stat_t        stat,
  input  wire cpm_pkg::in_word_t   in_data,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output cpm_pkg::out_word_t       out_data,
  input  wire logic [15:0]         speed_scale,
  input  wire logic [62:0]         collinear_tol_sq
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned IW = cpm_pkg::COORD_IN_W;
  localparam int unsigned SW = ((CW > IW) ? CW : IW) + 1;
  localparam int unsigned MW = cpm_pkg::MUL_W;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  function automatic coord_t clamp_coord(input logic signed [SW-1:0] v);
    coord_t r;
    if (v > SW'(CMAX)) begin
      r = CMAX;
    end else if (v < SW'(CMIN)) begin
      r = CMIN;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // Path state.
  cpm_pkg::in_word_t  in_r;
  coord_t             ref_r [3];
  coord_t             pnd_r [3];
  coord_t             erl_r [3];
  coord_t             npt_r [3];
  logic [15:0]        pspd_r;
  logic signed [15:0] psw_r;
  logic [7:0]         ptag_r;
  logic [1:0]         count_r;

  // Difference vectors a = N - P and c = E - P as sign and magnitude.
  logic [CW-1:0]      a_mag_r [3];
  logic [CW-1:0]      c_mag_r [3];
  logic               a_neg_r [3];
  logic               c_neg_r [3];

  // Multiplier stage and accumulators.
  logic [2*MW-1:0]    prod_r;
  logic               prod_neg_r;
  logic               prod_ovf_r;
  logic               prod_vld_r;
  cpm_pkg::kind_t     prod_kind_r;
  logic signed [65:0] t_r;
  logic signed [67:0] dot_r;
  logic [63:0]        sum_r;

  cpm_pkg::out_word_t out_r;
  logic               out_valid_r;

  // Per-lane views of the input coordinates.
  logic signed [IW-1:0] vin [3];
  assign vin[0] = in_r.coord_x;
  assign vin[1] = in_r.coord_y;
  assign vin[2] = in_r.coord_z;

  // New reference point.
  coord_t ref_nxt [3];
  always_comb begin
    logic signed [SW-1:0] vext;
    logic signed [SW-1:0] rsum;
    for (int i = 0; i < 3; i++) begin
      vext = SW'(vin[i]);
      rsum = SW'(ref_r[i]) + vext;
      priority if (in_r.command == cpm_pkg::CMD_REL) begin
        ref_nxt[i] = clamp_coord(rsum);
      end else if (in_r.command == cpm_pkg::CMD_ABS ||
                   in_r.command == cpm_pkg::CMD_SET_REF) begin
        ref_nxt[i] = clamp_coord(vext);
      end else if (in_r.command == cpm_pkg::CMD_REF_LAST &&
                   count_r != cpm_pkg::CNT_EMPTY) begin
        ref_nxt[i] = pnd_r[i];
      end else begin
        ref_nxt[i] = ref_r[i];
      end
    end
  end

  // Differences against the pending point.
  logic [CW-1:0] a_mag_nxt [3];
  logic [CW-1:0] c_mag_nxt [3];
  logic          a_neg_nxt [3];
  logic          c_neg_nxt [3];
  always_comb begin
    logic signed [CW:0] da;
    logic signed [CW:0] dc;
    logic signed [CW:0] aa;
    logic signed [CW:0] ac;
    for (int i = 0; i < 3; i++) begin
      da = (CW+1)'(npt_r[i]) - (CW+1)'(pnd_r[i]);
      dc = (CW+1)'(erl_r[i]) - (CW+1)'(pnd_r[i]);
      aa = da[CW] ? -da : da;
      ac = dc[CW] ? -dc : dc;
      a_neg_nxt[i] = da[CW];
      c_neg_nxt[i] = dc[CW];
      a_mag_nxt[i] = aa[CW-1:0];
      c_mag_nxt[i] = ac[CW-1:0];
    end
  end

  // Operand selection for the shared multiplier.
  cpm_pkg::kind_t     kind_sel;
  cpm_pkg::lane_t     la;
  cpm_pkg::lane_t     lc;
  logic signed [65:0] t_abs;
  logic [65:0]        t_mag;
  logic               t_ovf;
  logic [MW-1:0]      op_a;
  logic [MW-1:0]      op_b;
  logic               op_neg;
  logic               op_ovf;

  assign kind_sel = cpm_pkg::STEP_KIND[cmd.step];
  assign la       = cpm_pkg::STEP_A[cmd.step];
  assign lc       = cpm_pkg::STEP_C[cmd.step];
  assign t_abs    = t_r[65] ? -t_r : t_r;
  assign t_mag    = t_abs;
  assign t_ovf    = |t_mag[65:MW];

  always_comb begin
    if (kind_sel == cpm_pkg::K_SQ) begin
      op_a   = t_mag[MW-1:0];
      op_b   = t_mag[MW-1:0];
      op_neg = 1'b0;
      op_ovf = t_ovf;
    end else begin
      op_a   = MW'(a_mag_r[la]);
      op_b   = MW'(c_mag_r[lc]);
      op_neg = a_neg_r[la] ^ c_neg_r[lc];
      op_ovf = 1'b0;
    end
  end

  logic [2*MW-1:0] prod_nxt;
  assign prod_nxt = op_a * op_b;

  // Accumulation of the registered product.
  logic signed [65:0] p_ext;
  logic signed [65:0] p_sgn;
  logic [63:0]        sq_val;
  logic [64:0]        sum_ext;
  logic [63:0]        sum_sat;
  assign p_ext   = {2'b00, prod_r};
  assign p_sgn   = prod_neg_r ? -p_ext : p_ext;
  assign sq_val  = prod_ovf_r ? '1 : prod_r;
  assign sum_ext = {1'b0, sum_r} + {1'b0, sq_val};
  assign sum_sat = sum_ext[64] ? '1 : sum_ext[63:0];

  // Decision.
  logic collinear;
  logic same_speed;
  logic sync_ok;
  logic is_point;
  logic is_flush;
  logic merge;
  logic emit_req;

  assign collinear  = (sum_r < {1'b0, collinear_tol_sq}) && dot_r[67];
  assign same_speed = (in_r.speed_in == pspd_r) || (speed_scale == '0);
  assign sync_ok    = in_r.sync_window[15] || (in_r.sync_window > cpm_pkg::SYNC_ONE) ||
                      (!psw_r[15] && psw_r <= cpm_pkg::SYNC_ONE &&
                       in_r.sync_tag == ptag_r);
  assign is_point   = (in_r.command == cpm_pkg::CMD_REL) ||
                      (in_r.command == cpm_pkg::CMD_ABS);
  assign is_flush   = (in_r.command == cpm_pkg::CMD_FLUSH);
  assign merge      = cmd.calc_ran && collinear;
  assign emit_req   = (count_r != cpm_pkg::CNT_EMPTY) &&
                      ((is_point && !merge) || is_flush);

  assign stat.need_calc = (in_r.command == cpm_pkg::CMD_REL) &&
                          (count_r == cpm_pkg::CNT_BOTH) && same_speed && sync_ok;
  assign stat.emit_req  = emit_req;
  assign stat.out_free  = !out_valid_r || out_ready;

  // Result word built from the pending point.
  logic [31:0]           spd_prod;
  logic signed [SW-1:0]  pnd_ext [3];
  cpm_pkg::out_word_t    out_nxt;
  assign spd_prod = pspd_r * speed_scale;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pnd_ext[i] = SW'(pnd_r[i]);
    end
    out_nxt.out_x           = pnd_ext[0][IW-1:0];
    out_nxt.out_y           = pnd_ext[1][IW-1:0];
    out_nxt.out_z           = pnd_ext[2][IW-1:0];
    out_nxt.out_speed       = spd_prod[31:8];
    out_nxt.out_sync_window = psw_r;
    out_nxt.out_sync_tag    = ptag_r;
    out_nxt.last_point      = is_flush;
  end

  // Control state and the reference point.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= cpm_pkg::CNT_EMPTY;
      out_valid_r <= 1'b0;
      prod_vld_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ref_r[i] <= '0;
      end
    end else begin
      prod_vld_r <= cmd.mul_en;
      if (cmd.prep) begin
        ref_r <= ref_nxt;
      end
      if (cmd.commit) begin
        if (is_point && !merge) begin
          count_r <= (count_r != cpm_pkg::CNT_EMPTY) ? cpm_pkg::CNT_BOTH
                                                      : cpm_pkg::CNT_PENDING;
        end else if (is_flush) begin
          count_r <= cpm_pkg::CNT_EMPTY;
        end
      end
      if (cmd.commit && emit_req) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.prep) begin
      npt_r <= ref_nxt;
    end
    if (cmd.diff) begin
      a_mag_r <= a_mag_nxt;
      c_mag_r <= c_mag_nxt;
      a_neg_r <= a_neg_nxt;
      c_neg_r <= c_neg_nxt;
      sum_r   <= '0;
    end else if (prod_vld_r && prod_kind_r == cpm_pkg::K_SQ) begin
      sum_r <= sum_sat;
    end
    if (cmd.mul_en) begin
      prod_r      <= prod_nxt;
      prod_neg_r  <= op_neg;
      prod_ovf_r  <= op_ovf;
      prod_kind_r <= kind_sel;
    end
    if (prod_vld_r) begin
      unique case (prod_kind_r)
        cpm_pkg::K_LOAD:     t_r   <= p_sgn;
        cpm_pkg::K_SUB:      t_r   <= t_r - p_sgn;
        cpm_pkg::K_DOT_LOAD: dot_r <= 68'(p_sgn);
        cpm_pkg::K_DOT_ADD:  dot_r <= dot_r + 68'(p_sgn);
        default:             ;
      endcase
    end
    if (cmd.commit) begin
      if (is_point) begin
        pnd_r <= npt_r;
        if (!merge) begin
          if (count_r != cpm_pkg::CNT_EMPTY) begin
            erl_r <= pnd_r;
          end
          pspd_r <= in_r.speed_in;
          psw_r  <= in_r.sync_window;
          ptag_r <= in_r.sync_tag;
        end
      end
      if (emit_req) begin
        out_r <= out_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/core/cpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpm_ctrl
// Sequencer for one input word: reference update, optional collinearity
// test over the twelve-product schedule, and the commit that waits for the
// result register when a word has to be emitted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "collinear_point_merge_assert.svh"

module cpm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output cpm_pkg::dp_cmd_t       cmd,
  input  wire cpm_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIFF,
    S_MUL,
    S_TAIL,
    S_COMMIT
  } state_t;

  state_t          state_r;
  state_t          state_nxt;
  cpm_pkg::step_t  step_r;
  cpm_pkg::step_t  step_nxt;
  logic            calc_r;
  logic            calc_nxt;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    calc_nxt     = calc_r;
    cmd          = '0;
    cmd.step     = step_r;
    cmd.calc_ran = calc_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = stat.need_calc ? S_DIFF : S_COMMIT;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        step_nxt  = '0;
        calc_nxt  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (step_r == cpm_pkg::STEP_LAST) begin
          state_nxt = S_TAIL;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_TAIL: begin
        // Last square is still being accumulated.
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!stat.emit_req || stat.out_free) begin
          cmd.commit = 1'b1;
          calc_nxt   = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      calc_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      calc_r  <= calc_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  `CPM_ASSERT_IMPL(a_commit_needs_slot, cmd.commit && stat.emit_req, stat.out_free, "commit while result register busy")
  `CPM_ASSERT_NEXT(a_step_advance, state_r == S_MUL && step_r != cpm_pkg::STEP_LAST, state_r == S_MUL && step_r == cpm_pkg::step_t'($past(step_r) + 1'b1), "product schedule skipped a step")
  `CPM_ASSERT_IMPL(a_idle_clean, in_ready, !calc_r, "stale test flag while idle")
  `CPM_ASSERT_NEXT(a_diff_starts_mul, cmd.diff, state_r == S_MUL && step_r == '0 && calc_r, "test did not start at first product")

endmodule

`default_nettype wire

// ===== rtl/core/collinear_point_merge.sv =====
// ----------------------------------------------------------------------------
// collinear_point_merge
// Motion path builder that drops collinear middle points.
// ----------------------------------------------------------------------------
// A word is taken when in_valid and in_ready are high and handled one at a
// time. A word that needs no collinearity test (set reference, reference to
// last, flush, absolute points, the first two points, or a relative point
// whose speed or sync rules out merging) only goes through the prepare and
// commit states; in_ready is high again once the block is idle, so a new
// word waits until the previous one is through. A tested relative point
// also goes through the difference, multiply and tail states: the twelve
// products of the test (six cross product terms, the squares of the three
// cross terms, and three dot product terms) go one per cycle through a
// single 32x32 multiplier, then the last square is accumulated. A word that
// emits a result waits in commit only while the result register holds an
// earlier word out_ready has not taken. Cfg writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module collinear_point_merge #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cpm_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cpm_pkg::out_word_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [63:0]        cfg_data
);

  logic [15:0] speed_scale_r;
  logic [62:0] tol_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_scale_r <= cpm_pkg::SPEED_SCALE_RST;
      tol_sq_r      <= cpm_pkg::TOL_SQ_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cpm_pkg::REG_SPEED_SCALE: speed_scale_r <= cfg_data[15:0];
        cpm_pkg::REG_TOL_SQ:      tol_sq_r      <= cfg_data[62:0];
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  cpm_pkg::dp_cmd_t  cmd;
  cpm_pkg::dp_stat_t stat;

  cpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  cpm_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_data          (in_data),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_data         (out_data),
    .speed_scale      (speed_scale_r),
    .collinear_tol_sq (tol_sq_r)
  );

endmodule

`default_nettype wire
